FILE: rtl/core/tcw_pkg.sv
// Shared types, field widths and character constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_FW  = 5;
  localparam int COL_FW  = 7;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT_CHAR = 2'd0,
    KIND_PUT_AT   = 2'd1,
    KIND_READ     = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE  = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CODE    = 8'h20;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'h07;

  function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch,
                                                  logic [COLOR_W-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

FILE: rtl/core/tcw_in_if.sv
// Input item channel of the text console writer.
`timescale 1ns / 1ps

interface tcw_in_if;
  import tcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  cell_color;
  logic [ROW_FW-1:0]   row;
  logic [COL_FW-1:0]   col;

  modport source (output valid, kind, char_code, cell_color, row, col, input ready);
  modport sink   (input valid, kind, char_code, cell_color, row, col, output ready);
endinterface

FILE: rtl/core/tcw_out_if.sv
// Result item channel of the text console writer.
`timescale 1ns / 1ps

interface tcw_out_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_value;
  logic [ROW_FW-1:0]  cursor_row;
  logic [COL_FW-1:0]  cursor_col;
  logic               scrolled;

  modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

FILE: rtl/core/tcw_screen_ram.sv
// Screen cell memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [tcw_pkg::CELL_W-1:0]  rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/core/text_console_writer_top.sv
// Text console writer: ROWS x COLUMNS screen memory, cursor and scroll control.
`timescale 1ns / 1ps

// The screen lives in one synchronous memory of ROWS*COLUMNS 16-bit cells
// (attribute<<8 | character); rows are stored in rotated order behind a base
// row pointer, so a scroll moves no cells: it advances the pointer and
// blanks the one row that becomes the bottom line. Put-char, put-at and an
// off-screen read load the result register directly; an on-screen read
// passes through the read state first, as the memory's read data is
// registered. A step that scrolls then blanks COLUMNS cells (80 by default),
// one cell per cycle through the single write port, before the next item is
// taken. Clear and reset sweep every cell, ROWS*COLUMNS of them (2000 by
// default), during which no item is taken; configuration writes are taken at
// any time. The result of a step sits in an output register, so the next
// item is taken while that result is being consumed.

module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcw_in_if.sink                        in_ch,
  tcw_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_XW = ROW_W + 1;
  localparam int ROW_LW = ROW_FW + 1;
  localparam int COL_LW = COL_FW + 1;

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_XW-1:0] ROWS_X   = ROW_XW'(ROWS);
  localparam logic [ROW_LW-1:0] ROW_LIM  = ROW_LW'(ROWS);
  localparam logic [COL_LW-1:0] COL_LIM  = COL_LW'(COLUMNS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  function automatic logic [ROW_W-1:0] phys_row(logic [ROW_W-1:0] lrow,
                                                 logic [ROW_W-1:0] base);
    logic [ROW_XW-1:0] s;
    s = {1'b0, lrow} + {1'b0, base};
    if (s >= ROWS_X) begin
      s = s - ROWS_X;
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [ROW_W-1:0] prow,
                                               logic [COL_W-1:0] c);
    return AW'(int'(prow) * COLUMNS + int'(c));
  endfunction

  state_t              state_r;
  logic [ROW_W-1:0]    cursor_y_r, cursor_y_nxt;
  logic [COL_W-1:0]    cursor_x_r, cursor_x_nxt;
  logic [ROW_W-1:0]    base_r, base_nxt;
  logic [COLOR_W-1:0]  text_color_r;
  logic [COLOR_W-1:0]  fill_color_r;
  logic [ROW_W-1:0]    fill_row_r;
  logic [COL_W-1:0]    fill_col_r;
  logic                fill_all_r;
  logic                out_valid_r;
  logic [CELL_W-1:0]   out_value_r;
  logic                out_scrolled_r;

  logic                in_accept;
  logic                on_screen;
  logic [ROW_W-1:0]    tgt_row;
  logic [COL_W-1:0]    tgt_col;
  logic [AW-1:0]       tgt_addr;
  logic                wrap;
  logic                do_scroll;
  logic                do_clear;
  logic                step_we;
  logic [AW-1:0]       step_waddr;
  logic [CELL_W-1:0]   step_wdata;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [CELL_W-1:0]   ram_rdata;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign on_screen = ({1'b0, in_ch.row} < ROW_LIM) && ({1'b0, in_ch.col} < COL_LIM);
  assign tgt_row   = in_ch.row[ROW_W-1:0];
  assign tgt_col   = in_ch.col[COL_W-1:0];
  assign tgt_addr  = cell_addr(phys_row(tgt_row, base_r), tgt_col);

  always_comb begin
    cursor_y_nxt = cursor_y_r;
    cursor_x_nxt = cursor_x_r;
    base_nxt     = base_r;
    wrap         = 1'b0;
    do_scroll    = 1'b0;
    do_clear     = 1'b0;
    step_we      = 1'b0;
    ram_re       = 1'b0;
    step_waddr   = cell_addr(phys_row(cursor_y_r, base_r), cursor_x_r);
    step_wdata   = make_cell(in_ch.char_code, text_color_r);
    case (kind_t'(in_ch.kind))
      KIND_PUT_CHAR: begin
        if (in_ch.char_code == NEWLINE_CODE) begin
          wrap = 1'b1;
        end else begin
          step_we = in_accept;
          if (cursor_x_r == LAST_COL) begin
            wrap = 1'b1;
          end else begin
            cursor_x_nxt = cursor_x_r + 1'b1;
          end
        end
        if (wrap) begin
          cursor_x_nxt = '0;
          if (cursor_y_r == LAST_ROW) begin
            // rotate: old top row becomes the new bottom line
            do_scroll = 1'b1;
            base_nxt  = (base_r == LAST_ROW) ? '0 : base_r + 1'b1;
          end else begin
            cursor_y_nxt = cursor_y_r + 1'b1;
          end
        end
      end
      KIND_PUT_AT: begin
        step_we    = in_accept && on_screen;
        step_waddr = tgt_addr;
        step_wdata = make_cell(in_ch.char_code, in_ch.cell_color);
      end
      KIND_READ: begin
        ram_re = in_accept && on_screen;
      end
      KIND_CLEAR: begin
        do_clear     = 1'b1;
        cursor_x_nxt = '0;
        cursor_y_nxt = '0;
        base_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  // Blanking sweep owns the write port whenever it runs; items are held off then.
  assign ram_we    = (state_r == ST_FILL) ? 1'b1 : step_we;
  assign ram_waddr = (state_r == ST_FILL) ? cell_addr(fill_row_r, fill_col_r) : step_waddr;
  assign ram_wdata = (state_r == ST_FILL) ? make_cell(BLANK_CODE, fill_color_r) : step_wdata;

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tgt_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      fill_all_r   <= 1'b1;
      fill_row_r   <= '0;
      fill_col_r   <= '0;
      fill_color_r <= DEFAULT_COLOR;
      cursor_y_r   <= '0;
      cursor_x_r   <= '0;
      base_r       <= '0;
      text_color_r <= DEFAULT_COLOR;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cursor_y_r <= cursor_y_nxt;
            cursor_x_r <= cursor_x_nxt;
            base_r     <= base_nxt;
            if (ram_re) begin
              state_r <= ST_READ;
            end else begin
              out_valid_r    <= 1'b1;
              out_value_r    <= '0;
              out_scrolled_r <= do_scroll;
            end
            // blank color is latched when the sweep starts
            if (do_scroll) begin
              fill_row_r   <= base_r;
              fill_col_r   <= '0;
              fill_all_r   <= 1'b0;
              fill_color_r <= text_color_r;
              state_r      <= ST_FILL;
            end
            if (do_clear) begin
              fill_row_r   <= '0;
              fill_col_r   <= '0;
              fill_all_r   <= 1'b1;
              fill_color_r <= DEFAULT_COLOR;
              text_color_r <= DEFAULT_COLOR;
              state_r      <= ST_FILL;
            end
          end
        end
        ST_READ: begin
          out_valid_r    <= 1'b1;
          out_value_r    <= ram_rdata;
          out_scrolled_r <= 1'b0;
          state_r        <= ST_IDLE;
        end
        ST_FILL: begin
          if (fill_col_r == LAST_COL) begin
            fill_col_r <= '0;
            if (!fill_all_r || fill_row_r == LAST_ROW) begin
              state_r <= ST_IDLE;
            end else begin
              fill_row_r <= fill_row_r + 1'b1;
            end
          end else begin
            fill_col_r <= fill_col_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cfg_we) begin
        text_color_r <= cfg_wdata;
      end
    end
  end

  // At most one result is pending and it is always the latest step, so the
  // live cursor registers double as the result's cursor fields.
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_value_r;
  assign out_ch.cursor_row = ROW_FW'(cursor_y_r);
  assign out_ch.cursor_col = COL_FW'(cursor_x_r);
  assign out_ch.scrolled   = out_scrolled_r;

endmodule
